// File: hw/rtl/plps_pkg.sv
`timescale 1ns / 1ps
package plps_pkg;

  localparam int NUM_LEDS     = 5;
  localparam int NUM_PATTERNS = 9;
  localparam int MAX_STEPS    = 16;

  localparam int CMD_W    = 2;
  localparam int LED_W    = 3;
  localparam int PAT_W    = 4;
  localparam int POS_W    = 5;
  localparam int MS_W     = 11;
  localparam int LEVELS_W = 5;

  localparam int SEL_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int PIDX_W    = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int MEM_DEPTH = NUM_LEDS * NUM_PATTERNS;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

  localparam logic [PAT_W-1:0] NONE_SHOWN = 4'd9;

  typedef enum logic [1:0] {
    KIND_STOP  = 2'd0,
    KIND_LOOP  = 2'd1,
    KIND_LEVEL = 2'd2
  } step_kind_t;

  typedef struct packed {
    step_kind_t       kind;
    logic             on;
    logic [MS_W-1:0]  ms;
  } step_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_APPLY,
    S_TICK,
    S_EXEC_RD,
    S_EXEC,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic apply;
    logic tick_chk;
    logic exec_rd;
    logic exec;
    logic sel_inc;
    logic out_load;
  } dp_ctl_t;

  typedef struct packed {
    logic is_tick;
    logic cmd_ok;
    logic apply_exec;
    logic tick_expire;
    logic sel_last;
    logic out_free;
  } dp_sts_t;

  function automatic step_t mk_level(input logic on, input logic [MS_W-1:0] ms);
    step_t s;
    s.kind = KIND_LEVEL;
    s.on   = on;
    s.ms   = ms;
    return s;
  endfunction

  function automatic step_t mk_mark(input step_kind_t kind);
    step_t s;
    s.kind = kind;
    s.on   = 1'b0;
    s.ms   = '0;
    return s;
  endfunction

  // Pattern ROM; anything past a pattern's list reads as a stop mark.
  function automatic step_t rom_step(input logic [PAT_W-1:0] p, input logic [POS_W-1:0] pos);
    step_t s;
    s = mk_mark(KIND_STOP);
    if (int'(pos) < MAX_STEPS) begin
      case (p)
        4'd0: if (pos < 5'd14) s = mk_level(~pos[0], 11'd50);
        4'd1: case (pos)
          5'd0: s = mk_level(1'b1, 11'd200);
          5'd1: s = mk_level(1'b0, 11'd200);
          5'd2: s = mk_mark(KIND_LOOP);
          default: s = mk_mark(KIND_STOP);
        endcase
        4'd2: case (pos)
          5'd0: s = mk_level(1'b1, 11'd1000);
          5'd1: s = mk_mark(KIND_LOOP);
          default: s = mk_mark(KIND_STOP);
        endcase
        4'd3: case (pos)
          5'd0: s = mk_level(1'b1, 11'd200);
          5'd1: s = mk_level(1'b0, 11'd800);
          5'd2: s = mk_mark(KIND_LOOP);
          default: s = mk_mark(KIND_STOP);
        endcase
        4'd4: case (pos)
          5'd0: s = mk_level(1'b1, 11'd500);
          5'd1: s = mk_level(1'b0, 11'd500);
          5'd2: s = mk_mark(KIND_LOOP);
          default: s = mk_mark(KIND_STOP);
        endcase
        4'd5: case (pos)
          5'd0: s = mk_level(1'b1, 11'd50);
          5'd1: s = mk_level(1'b0, 11'd250);
          5'd2: s = mk_mark(KIND_LOOP);
          default: s = mk_mark(KIND_STOP);
        endcase
        4'd6: case (pos)
          5'd0: s = mk_level(1'b1, 11'd50);
          5'd1: s = mk_level(1'b0, 11'd450);
          5'd2: s = mk_mark(KIND_LOOP);
          default: s = mk_mark(KIND_STOP);
        endcase
        4'd7: case (pos)
          5'd0: s = mk_level(1'b1, 11'd50);
          5'd1: s = mk_level(1'b0, 11'd1950);
          5'd2: s = mk_mark(KIND_LOOP);
          default: s = mk_mark(KIND_STOP);
        endcase
        4'd8: case (pos)
          5'd0: s = mk_level(1'b1, 11'd10);
          5'd1: s = mk_level(1'b0, 11'd0);
          default: s = mk_mark(KIND_STOP);
        endcase
        default: s = mk_mark(KIND_STOP);
      endcase
    end
    return s;
  endfunction

endpackage

// File: hw/rtl/plps_ctrl.sv
`timescale 1ns / 1ps
module plps_ctrl import plps_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_ctl_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (sts.is_tick)     state_nxt = S_TICK;
        else if (sts.cmd_ok) state_nxt = S_APPLY;
        else                 state_nxt = S_RESULT;
      end
      S_APPLY: begin
        state_nxt = sts.apply_exec ? S_EXEC_RD : S_RESULT;
      end
      S_TICK: begin
        if (sts.tick_expire)   state_nxt = S_EXEC_RD;
        else if (sts.sel_last) state_nxt = S_RESULT;
      end
      S_EXEC_RD: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = (sts.is_tick && !sts.sel_last) ? S_TICK : S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        ctl.capture = in_valid;
      end
      S_DECODE: begin
      end
      S_APPLY: begin
        ctl.apply = 1'b1;
      end
      S_TICK: begin
        ctl.tick_chk = 1'b1;
        ctl.sel_inc  = !sts.tick_expire && !sts.sel_last;
      end
      S_EXEC_RD: begin
        ctl.exec_rd = 1'b1;
      end
      S_EXEC: begin
        ctl.exec    = 1'b1;
        ctl.sel_inc = sts.is_tick && !sts.sel_last;
      end
      S_RESULT: begin
        ctl.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/plps_datapath.sv
`timescale 1ns / 1ps
module plps_datapath import plps_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [LED_W-1:0]    in_led_index,
  input  logic [PAT_W-1:0]    in_pattern,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LEVELS_W-1:0] out_led_levels,
  output logic [PAT_W-1:0]    out_shown_pattern,
  input  dp_ctl_t             ctl,
  output dp_sts_t             sts
);

  logic [CMD_W-1:0] cmd_r;
  logic [LED_W-1:0] led_r;
  logic [PAT_W-1:0] pat_r;
  logic [SEL_W-1:0] sel_r, sel_nxt;

  logic [NUM_PATTERNS-1:0] mask_r  [NUM_LEDS];
  logic [NUM_PATTERNS-1:0] mask_nxt[NUM_LEDS];
  logic [PAT_W-1:0]        shown_r  [NUM_LEDS];
  logic [PAT_W-1:0]        shown_nxt[NUM_LEDS];
  logic [MS_W-1:0]         cnt_r  [NUM_LEDS];
  logic [MS_W-1:0]         cnt_nxt[NUM_LEDS];
  logic                    tmr_r  [NUM_LEDS];
  logic                    tmr_nxt[NUM_LEDS];
  logic                    lit_r  [NUM_LEDS];
  logic                    lit_nxt[NUM_LEDS];

  // step positions; an entry is meaningful only while its mask bit is set
  logic [POS_W-1:0]  pos_mem [MEM_DEPTH];
  logic [POS_W-1:0]  rd_pos_r;
  logic [MEM_AW-1:0] mem_addr;
  logic              mem_we;
  logic [POS_W-1:0]  mem_wdata;

  logic                out_valid_r, out_valid_nxt;
  logic [LEVELS_W-1:0] out_levels_r;
  logic [PAT_W-1:0]    out_shown_r;
  logic [LEVELS_W-1:0] levels_now;
  logic [PAT_W-1:0]    shown_now;

  logic                    run;
  logic [NUM_PATTERNS-1:0] mask_sel, apply_mask, exec_mask;
  logic [PAT_W-1:0]        shown_sel, apply_shown, exec_shown;
  logic                    was_shown, apply_exec, exec_valid;
  step_t                   st;
  logic [POS_W-1:0]        pos_inc;

  function automatic logic [PAT_W-1:0] first_running(input logic [NUM_PATTERNS-1:0] m);
    logic [PAT_W-1:0] res;
    res = NONE_SHOWN;
    for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
      if (m[i]) res = PAT_W'(i);
    end
    return res;
  endfunction

  always_comb begin
    mask_sel   = mask_r[sel_r];
    shown_sel  = shown_r[sel_r];
    run        = (cmd_r == CMD_RUN);

    apply_mask = mask_sel;
    apply_mask[PIDX_W'(pat_r)] = run;
    apply_shown = first_running(apply_mask);
    was_shown   = (shown_sel == pat_r);
    apply_exec  = run ? ((apply_shown == pat_r) && !was_shown) : was_shown;

    exec_valid = int'(shown_sel) < NUM_PATTERNS;
    st         = rom_step(shown_sel, rd_pos_r);
    exec_mask  = mask_sel;
    if (exec_valid) exec_mask[PIDX_W'(shown_sel)] = 1'b0;
    exec_shown = first_running(exec_mask);
    pos_inc    = rd_pos_r + POS_W'(1);
  end

  always_comb begin
    mem_addr = MEM_AW'(sel_r) * MEM_AW'(NUM_PATTERNS)
             + MEM_AW'(ctl.apply ? pat_r : shown_sel);
  end

  always_comb begin
    mask_nxt  = mask_r;
    shown_nxt = shown_r;
    cnt_nxt   = cnt_r;
    tmr_nxt   = tmr_r;
    lit_nxt   = lit_r;
    mem_we    = 1'b0;
    mem_wdata = '0;

    if (ctl.apply) begin
      mask_nxt[sel_r]  = apply_mask;
      shown_nxt[sel_r] = apply_shown;
      lit_nxt[sel_r]   = 1'b0;
      if (apply_exec) tmr_nxt[sel_r] = 1'b0;
      mem_we = run;
    end

    if (ctl.tick_chk && tmr_r[sel_r]) begin
      if (cnt_r[sel_r] > MS_W'(1)) begin
        cnt_nxt[sel_r] = cnt_r[sel_r] - MS_W'(1);
      end else begin
        cnt_nxt[sel_r] = '0;
        tmr_nxt[sel_r] = 1'b0;
      end
    end

    if (ctl.exec) begin
      if (!exec_valid) begin
        lit_nxt[sel_r] = 1'b0;
      end else begin
        case (st.kind)
          KIND_LOOP: begin
            mem_we         = 1'b1;
            cnt_nxt[sel_r] = MS_W'(1);
            tmr_nxt[sel_r] = 1'b1;
          end
          KIND_LEVEL: begin
            mem_we         = 1'b1;
            mem_wdata      = pos_inc;
            lit_nxt[sel_r] = st.on;
            cnt_nxt[sel_r] = (st.ms == '0) ? MS_W'(1) : st.ms;
            tmr_nxt[sel_r] = 1'b1;
          end
          default: begin
            // stop mark: drop the pattern, fall back to the next one, timer idles
            mask_nxt[sel_r]  = exec_mask;
            shown_nxt[sel_r] = exec_shown;
            lit_nxt[sel_r]   = 1'b0;
            tmr_nxt[sel_r]   = 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    sel_nxt = sel_r;
    if (ctl.capture) begin
      sel_nxt = (in_cmd == CMD_TICK) ? '0 : SEL_W'(in_led_index);
    end else if (ctl.sel_inc) begin
      sel_nxt = sel_r + SEL_W'(1);
    end
  end

  always_comb begin
    levels_now = '0;
    for (int i = 0; i < LEVELS_W; i++) begin
      if (i < NUM_LEDS) levels_now[i] = lit_r[i];
    end
    shown_now = (int'(led_r) < NUM_LEDS) ? shown_r[SEL_W'(led_r)] : NONE_SHOWN;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (ctl.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        mask_r[i]  <= '0;
        shown_r[i] <= NONE_SHOWN;
        cnt_r[i]   <= '0;
        tmr_r[i]   <= 1'b0;
        lit_r[i]   <= 1'b0;
      end
    end else begin
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
      mask_r      <= mask_nxt;
      shown_r     <= shown_nxt;
      cnt_r       <= cnt_nxt;
      tmr_r       <= tmr_nxt;
      lit_r       <= lit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_cmd;
      led_r <= in_led_index;
      pat_r <= in_pattern;
    end
    if (ctl.out_load) begin
      out_levels_r <= levels_now;
      out_shown_r  <= shown_now;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) pos_mem[mem_addr] <= mem_wdata;
    if (ctl.exec_rd && exec_valid) rd_pos_r <= pos_mem[mem_addr];
  end

  always_comb begin
    sts.is_tick     = (cmd_r == CMD_TICK);
    sts.cmd_ok      = ((cmd_r == CMD_RUN) || (cmd_r == CMD_STOP))
                   && (int'(led_r) < NUM_LEDS) && (int'(pat_r) < NUM_PATTERNS);
    sts.apply_exec  = apply_exec;
    sts.tick_expire = tmr_r[sel_r] && (cnt_r[sel_r] <= MS_W'(1));
    sts.sel_last    = (int'(sel_r) == NUM_LEDS - 1);
    sts.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_led_levels    = out_levels_r;
  assign out_shown_pattern = out_shown_r;

endmodule

// File: hw/rtl/priority_led_pattern_sequencer.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall   in_cmd, in_led_index, in_pattern
// out_      output     out_valid / out_stall out_led_levels, out_shown_pattern
//
// One item at a time. A tick walks the LEDs one per cycle, plus S_EXEC_RD and
// S_EXEC (registered step-position read) for each LED whose timer expires. Run
// or stop passes S_APPLY, then S_EXEC_RD and S_EXEC if a step executes at once;
// other codes go straight to S_RESULT. Synchronous active-low reset stops every
// pattern and darkens all LEDs. A result waits in the output register while the
// next transfer is taken; only a second result waits for out_stall to drop.
module priority_led_pattern_sequencer import plps_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [LED_W-1:0]    in_led_index,
  input  logic [PAT_W-1:0]    in_pattern,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LEVELS_W-1:0] out_led_levels,
  output logic [PAT_W-1:0]    out_shown_pattern
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  plps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  plps_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_cmd),
    .in_led_index      (in_led_index),
    .in_pattern        (in_pattern),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_led_levels    (out_led_levels),
    .out_shown_pattern (out_shown_pattern),
    .ctl               (ctl),
    .sts               (sts)
  );

endmodule
